@@ src/perfect_number_test_top_macros.svh @@
// assertion macros for the perfect number test block
`ifndef PERFECT_NUMBER_TEST_TOP_MACROS_SVH
`define PERFECT_NUMBER_TEST_TOP_MACROS_SVH

`ifndef SYNTHESIS

// generic clocked assertion with explicit clock and active-low reset
`define PNT_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assertion on the block clock and reset
`define PNT_ASSERT(lbl, prop, msg) \
  `PNT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define PNT_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define PNT_ASSERT(lbl, prop, msg)

`endif

`endif

@@ src/pnt_pkg.sv @@
package pnt_pkg;

  // default candidate width
  localparam int NUM_WIDTH_DEF = 32;

  // width of the reported divisor sum
  localparam int SUM_WIDTH = 35;

endpackage

@@ src/perfect_number_test_top.sv @@
// Perfect number test: reports the aliquot sum of a candidate and whether it
// equals the candidate.
// Input channel: in_valid_i / in_ready_o carry candidate_i (low NUM_WIDTH bits).
// Output channel: out_valid_o / out_ready_i carry divisor_sum_o and is_perfect_o.
// Divisors are found by pairing each trial divisor d <= sqrt(n) with n / d.
// Each trial uses a bit-serial restoring divider, one quotient bit per cycle.
// Throughput: one candidate at a time; the next transaction is taken once the
// current result has moved into the output register.
// A finished result waits in the output register while the receiver stalls;
// a new candidate can be accepted and worked on meanwhile, and the next result
// is held back until the waiting one is taken.
// Reset clears all control state: no result is valid and the block is ready.
`include "perfect_number_test_top_macros.svh"

module perfect_number_test_top import pnt_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SUM_WIDTH-1:0] divisor_sum_o,
  output logic                 is_perfect_o
);

  // accumulator wide enough for the full sum, wrapping at 64 bits
  localparam int ACC_RAW = (NUM_WIDTH + 3 > 64) ? 64 : NUM_WIDTH + 3;
  localparam int ACC_W   = (ACC_RAW > SUM_WIDTH) ? ACC_RAW : SUM_WIDTH;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [NUM_WIDTH-1:0] d_q, d_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic                 n_ge2_q, n_ge2_d;
  logic                 out_valid_q, out_valid_d;
  logic [SUM_WIDTH-1:0] out_sum_q, out_sum_d;
  logic                 out_perf_q, out_perf_d;

  logic                 div_start;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quot;
  logic [NUM_WIDTH-1:0] div_rem;

  logic                 in_acc;
  logic                 out_free;
  logic                 cand_ge2;
  logic [ACC_W-1:0]     pair_sum;
  logic [ACC_W-1:0]     aliquot;
  logic [ACC_W-1:0]     n_ext;

  pnt_div #(
    .W(NUM_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign cand_ge2   = (candidate_i > NUM_WIDTH'(1));
  assign div_start  = (state_q == ST_LAUNCH);

  // divisor pair d and n / d, the cofactor counted once when equal
  assign pair_sum = ACC_W'(d_q) + ((div_quot != d_q) ? ACC_W'(div_quot) : '0);

  // sum of all divisors less the number itself
  assign n_ext   = ACC_W'(n_q);
  assign aliquot = acc_q - n_ext;

  // sequencer over trial divisors
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    acc_d       = acc_q;
    n_ge2_d     = n_ge2_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_perf_d  = out_perf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d     = candidate_i;
          d_d     = NUM_WIDTH'(1);
          n_ge2_d = cand_ge2;
          // small candidates preload the accumulator so the sum comes out zero
          acc_d   = cand_ge2 ? '0 : ACC_W'(candidate_i);
          state_d = cand_ge2 ? ST_LAUNCH : ST_FIN;
        end
      end
      ST_LAUNCH: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (d_q > div_quot) begin
            state_d = ST_FIN;
          end else begin
            if (div_rem == '0) begin
              acc_d = acc_q + pair_sum;
            end
            d_d     = d_q + NUM_WIDTH'(1);
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = aliquot[SUM_WIDTH-1:0];
          out_perf_d  = n_ge2_q && (aliquot == n_ext);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    d_q        <= d_d;
    acc_q      <= acc_d;
    n_ge2_q    <= n_ge2_d;
    out_sum_q  <= out_sum_d;
    out_perf_q <= out_perf_d;
  end

  assign out_valid_o   = out_valid_q;
  assign divisor_sum_o = out_sum_q;
  assign is_perfect_o  = out_perf_q;

  // checks on sequencing and results
  `PNT_ASSERT(a_done_in_div, div_done |-> (state_q == ST_DIV), "divider done outside trial")
  `PNT_ASSERT(a_nonzero_divisor, (state_q == ST_DIV) |-> (d_q != '0), "trial divisor is zero")
  `PNT_ASSERT(a_busy_after_accept, in_acc |=> !in_ready_o, "ready stayed high after accept")
  `PNT_ASSERT(a_perfect_sum, (out_valid_o && is_perfect_o) |-> (divisor_sum_o != '0), "perfect result with zero sum")

endmodule

@@ src/pnt_div.sv @@
module pnt_div import pnt_pkg::*; #(
  parameter int W = NUM_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  num_q, num_d;
  logic [W-1:0]  rem_q, rem_d;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // one restoring step: bring in the next dividend bit, try the subtract
  assign shifted = {rem_q, num_q[W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign fits    = ~diff[W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
      num_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // quotient bits shift in from the bottom as dividend bits leave the top
      num_d = {num_q[W-2:0], fits};
      rem_d = fits ? diff[W-1:0] : shifted[W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule
